[hdl/wrb_pkg.sv]
package wrb_pkg;

   localparam int CNT_W = 7;

   localparam logic [2:0] CMD_PUSH    = 3'd0;
   localparam logic [2:0] CMD_MARK    = 3'd1;
   localparam logic [2:0] CMD_POP_ONE = 3'd2;
   localparam logic [2:0] CMD_POP_ALL = 3'd3;
   localparam logic [2:0] CMD_FINISH  = 3'd4;

   typedef struct packed {
      logic [2:0]  command;
      logic [63:0] entry_time;
      logic [31:0] entry_payload;
      logic [63:0] seen_time;
   } req_type;

   typedef struct packed {
      logic             item_valid;
      logic [63:0]      item_time;
      logic [31:0]      item_payload;
      logic             last;
      logic             push_dropped;
      logic [CNT_W-1:0] occupancy;
      logic [CNT_W-1:0] high_water;
      logic [31:0]      pushed_total;
      logic [31:0]      dropped_total;
      logic [31:0]      popped_total;
      logic             drained;
   } rsp_type;

endpackage

[hdl/wrb_fifo.sv]
module wrb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (PW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= din;
      end
   end

endmodule

[hdl/wrb_back.sv]
module wrb_back
   import wrb_pkg::*;
#(
   parameter int CAPACITY     = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] max_entries,
   input  logic [63:0]      order_delay,
   input  logic             cmd_empty,
   input  req_type          cmd_rd,
   output logic             cmd_pop,
   input  logic             out_full,
   output logic             out_push,
   output rsp_type          out_wr
);
   localparam int AW = $clog2(CAPACITY);
   localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
   localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_PUSH_EV = 4'd1;
   localparam logic [3:0] ST_INS_RD  = 4'd2;
   localparam logic [3:0] ST_INS_CMP = 4'd3;
   localparam logic [3:0] ST_POP_RD  = 4'd4;
   localparam logic [3:0] ST_POP_CHK = 4'd5;
   localparam logic [3:0] ST_EMIT    = 4'd6;

   function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                          input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(CAPACITY)) begin
         sum = sum - (CNT_W+1)'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   logic [63:0]    mem_time [CAPACITY];
   logic [PW-1:0]  mem_pay  [CAPACITY];
   logic [63:0]    rd_time_ff;
   logic [PW-1:0]  rd_pay_ff;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic           wr_en;
   logic [63:0]    wr_time;
   logic [PW-1:0]  wr_pay;

   logic [3:0]       state_ff, state_in, ret_ff, ret_in;
   req_type          cmd_ff, cmd_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in, k_ff, k_in, peak_ff, peak_in;
   logic [63:0]      wm_ff, wm_in, thr_ff;
   logic             flush_ff, flush_in, dropped_ff, dropped_in;
   logic             pend_v_ff, pend_v_in;
   logic [31:0]      pushc_ff, pushc_in, dropc_ff, dropc_in, popc_ff, popc_in;
   rsp_type          res_ff, res_in, pend_ff, pend_in;
   logic [CNT_W-1:0] lim;
   logic             ins_new, stop, ready;
   logic [AW-1:0]    ins_pos;
   rsp_type          item;

   assign lim = (max_entries == '0 || max_entries > CAP) ? CAP : max_entries;
   assign out_wr = res_ff;

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      cmd_in     = cmd_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      k_in       = k_ff;
      peak_in    = peak_ff;
      wm_in      = wm_ff;
      flush_in   = flush_ff;
      dropped_in = dropped_ff;
      pend_v_in  = pend_v_ff;
      pushc_in   = pushc_ff;
      dropc_in   = dropc_ff;
      popc_in    = popc_ff;
      res_in     = res_ff;
      pend_in    = pend_ff;
      cmd_pop    = 1'b0;
      out_push   = 1'b0;
      rd_addr    = head_ff;
      wr_en      = 1'b0;
      wr_addr    = head_ff;
      wr_time    = cmd_ff.entry_time;
      wr_pay     = cmd_ff.entry_payload[PW-1:0];
      ins_new    = 1'b0;
      ins_pos    = head_ff;
      stop       = 1'b0;
      ready      = 1'b0;
      item       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop    = 1'b1;
               cmd_in     = cmd_rd;
               dropped_in = 1'b0;
               pend_v_in  = 1'b0;
               ret_in     = ST_IDLE;
               res_in              = '0;
               res_in.last         = 1'b1;
               res_in.occupancy    = count_ff;
               res_in.high_water   = peak_ff;
               res_in.pushed_total = pushc_ff;
               res_in.dropped_total = dropc_ff;
               res_in.popped_total = popc_ff;
               res_in.drained      = flush_ff && count_ff == '0;
               case (cmd_rd.command)
                  CMD_PUSH: state_in = ST_PUSH_EV;
                  CMD_MARK: begin
                     wm_in    = cmd_rd.seen_time;
                     state_in = ST_EMIT;
                  end
                  CMD_POP_ONE, CMD_POP_ALL: state_in = ST_POP_RD;
                  CMD_FINISH: begin
                     flush_in       = 1'b1;
                     res_in.drained = count_ff == '0;
                     state_in       = ST_EMIT;
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_PUSH_EV: begin
            if (count_ff >= lim && count_ff != '0) begin
               head_in    = wrap(head_ff, CNT_W'(1));
               count_in   = count_ff - 1'b1;
               dropc_in   = dropc_ff + 1'b1;
               dropped_in = 1'b1;
            end
            k_in     = count_in;
            state_in = ST_INS_RD;
         end
         // walk down from the tail, moving later entries up one slot
         ST_INS_RD: begin
            if (k_ff == '0) begin
               ins_new = 1'b1;
               ins_pos = head_ff;
            end else begin
               rd_addr  = wrap(head_ff, k_ff - 1'b1);
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (rd_time_ff > cmd_ff.entry_time) begin
               wr_en    = 1'b1;
               wr_addr  = wrap(head_ff, k_ff);
               wr_time  = rd_time_ff;
               wr_pay   = rd_pay_ff;
               k_in     = k_ff - 1'b1;
               state_in = ST_INS_RD;
            end else begin
               ins_new = 1'b1;
               ins_pos = wrap(head_ff, k_ff);
            end
         end
         ST_POP_RD: begin
            if (count_ff == '0) begin
               stop = 1'b1;
            end else begin
               rd_addr  = head_ff;
               state_in = ST_POP_CHK;
            end
         end
         ST_POP_CHK: begin
            ready = flush_ff || rd_time_ff <= thr_ff;
            if (ready) begin
               head_in  = wrap(head_ff, CNT_W'(1));
               count_in = count_ff - 1'b1;
               popc_in  = popc_ff + 1'b1;
               item.item_valid    = 1'b1;
               item.item_time     = rd_time_ff;
               item.item_payload  = 32'(rd_pay_ff);
               item.last          = cmd_ff.command == CMD_POP_ONE;
               item.occupancy     = count_in;
               item.high_water    = peak_ff;
               item.pushed_total  = pushc_ff;
               item.dropped_total = dropc_ff;
               item.popped_total  = popc_in;
               item.drained       = flush_ff && count_in == '0;
               if (cmd_ff.command == CMD_POP_ONE) begin
                  res_in   = item;
                  ret_in   = ST_IDLE;
                  state_in = ST_EMIT;
               end else if (pend_v_ff) begin
                  // previous entry was not the final one
                  res_in   = pend_ff;
                  pend_in  = item;
                  ret_in   = ST_POP_RD;
                  state_in = ST_EMIT;
               end else begin
                  pend_in   = item;
                  pend_v_in = 1'b1;
                  state_in  = ST_POP_RD;
               end
            end else begin
               stop = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = ret_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (stop) begin
         if (pend_v_ff) begin
            res_in      = pend_ff;
            res_in.last = 1'b1;
         end
         pend_v_in = 1'b0;
         ret_in    = ST_IDLE;
         state_in  = ST_EMIT;
      end

      if (ins_new) begin
         wr_en    = 1'b1;
         wr_addr  = ins_pos;
         wr_time  = cmd_ff.entry_time;
         wr_pay   = cmd_ff.entry_payload[PW-1:0];
         count_in = count_ff + 1'b1;
         pushc_in = pushc_ff + 1'b1;
         peak_in  = (count_in > peak_ff) ? count_in : peak_ff;
         res_in               = '0;
         res_in.last          = 1'b1;
         res_in.push_dropped  = dropped_ff;
         res_in.occupancy     = count_in;
         res_in.high_water    = peak_in;
         res_in.pushed_total  = pushc_in;
         res_in.dropped_total = dropc_ff;
         res_in.popped_total  = popc_ff;
         res_in.drained       = flush_ff && count_in == '0;
         ret_in   = ST_IDLE;
         state_in = ST_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ff     <= ST_IDLE;
         head_ff    <= '0;
         count_ff   <= '0;
         k_ff       <= '0;
         peak_ff    <= '0;
         wm_ff      <= '0;
         thr_ff     <= '0;
         flush_ff   <= 1'b0;
         dropped_ff <= 1'b0;
         pend_v_ff  <= 1'b0;
         pushc_ff   <= '0;
         dropc_ff   <= '0;
         popc_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         k_ff       <= k_in;
         peak_ff    <= peak_in;
         wm_ff      <= wm_in;
         thr_ff     <= (wm_ff > order_delay) ? wm_ff - order_delay : '0;
         flush_ff   <= flush_in;
         dropped_ff <= dropped_in;
         pend_v_ff  <= pend_v_in;
         pushc_ff   <= pushc_in;
         dropc_ff   <= dropc_in;
         popc_ff    <= popc_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      res_ff  <= res_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_time[wr_addr] <= wr_time;
         mem_pay[wr_addr]  <= wr_pay;
      end
      rd_time_ff <= mem_time[rd_addr];
      rd_pay_ff  <= mem_pay[rd_addr];
   end

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP) else $error("occupancy above capacity");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= count_ff) else $error("high water below occupancy");
   a_take: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> state_ff != ST_IDLE) else $error("command taken but engine idle");
   a_word: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_wr.occupancy <= out_wr.high_water)
      else $error("result occupancy above high water");

endmodule

[hdl/watermark_reorder_buffer_top.sv]
// Timestamp reorder buffer. Commands enter a two-word queue; a sequencer keeps
// entries sorted by time in a circular RAM and posts result words to a
// two-word output queue. Per command: push walks the RAM down from the
// newest entry, moving each held entry with a later time up one slot (ties
// stay in push order); watermark and finish post one word; pop one posts one
// word; pop all posts one word per released entry, or one word if none is
// ready. A full output queue stalls the sequencer only. No clearing pass
// after reset.
module watermark_reorder_buffer_top
   import wrb_pkg::*;
#(
   parameter int CAPACITY     = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [2:0]       req_command,
   input  logic [63:0]      req_entry_time,
   input  logic [31:0]      req_entry_payload,
   input  logic [63:0]      req_seen_time,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic             rsp_item_valid,
   output logic [63:0]      rsp_item_time,
   output logic [31:0]      rsp_item_payload,
   output logic             rsp_last,
   output logic             rsp_push_dropped,
   output logic [CNT_W-1:0] rsp_occupancy,
   output logic [CNT_W-1:0] rsp_high_water,
   output logic [31:0]      rsp_pushed_total,
   output logic [31:0]      rsp_dropped_total,
   output logic [31:0]      rsp_popped_total,
   output logic             rsp_drained,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [63:0]      csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   logic [CNT_W-1:0] max_entries_ff;
   logic [63:0]      order_delay_ff;
   logic             csr_wr;
   req_type          req_word, cmd_rd;
   logic [$bits(req_type)-1:0] cmd_dout;
   logic [$bits(rsp_type)-1:0] rsp_dout;
   rsp_type          out_wr, rsp_word;
   logic             cmd_empty, cmd_pop, out_full, out_push;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[3] ? order_delay_ff : 64'(max_entries_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= '0;
         order_delay_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[3]) begin
            order_delay_ff <= csr_pwdata;
         end else begin
            max_entries_ff <= csr_pwdata[CNT_W-1:0];
         end
      end
   end

   assign req_word.command       = req_command;
   assign req_word.entry_time    = req_entry_time;
   assign req_word.entry_payload = req_entry_payload;
   assign req_word.seen_time     = req_seen_time;

   wrb_fifo #(.WIDTH($bits(req_type)), .DEPTH(2)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (req_word),
      .full  (req_full),
      .pop   (cmd_pop),
      .dout  (cmd_dout),
      .empty (cmd_empty)
   );
   assign cmd_rd = req_type'(cmd_dout);

   wrb_back #(.CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .max_entries (max_entries_ff),
      .order_delay (order_delay_ff),
      .cmd_empty   (cmd_empty),
      .cmd_rd      (cmd_rd),
      .cmd_pop     (cmd_pop),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_wr      (out_wr)
   );

   wrb_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_wr),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (rsp_dout),
      .empty (rsp_empty)
   );
   assign rsp_word = rsp_type'(rsp_dout);

   assign rsp_item_valid    = rsp_word.item_valid;
   assign rsp_item_time     = rsp_word.item_time;
   assign rsp_item_payload  = rsp_word.item_payload;
   assign rsp_last          = rsp_word.last;
   assign rsp_push_dropped  = rsp_word.push_dropped;
   assign rsp_occupancy     = rsp_word.occupancy;
   assign rsp_high_water    = rsp_word.high_water;
   assign rsp_pushed_total  = rsp_word.pushed_total;
   assign rsp_dropped_total = rsp_word.dropped_total;
   assign rsp_popped_total  = rsp_word.popped_total;
   assign rsp_drained       = rsp_word.drained;

endmodule

[verif/watermark_reorder_buffer_top_tb.sv]
`timescale 1ns / 1ps

module watermark_reorder_buffer_top_tb;
   import wrb_pkg::*;

   localparam int          DEPTH            = 64;
   localparam logic [3:0]  ADDR_MAX_ENTRIES = 4'd0;
   localparam logic [3:0]  ADDR_ORDER_DELAY = 4'd8;
   localparam logic [63:0] ALL_ONES         = {64{1'b1}};
   localparam logic [2:0]  CMD_UNUSED_5     = 3'd5;
   localparam logic [2:0]  CMD_UNUSED_6     = 3'd6;
   localparam logic [2:0]  CMD_UNUSED_7     = 3'd7;

   typedef struct {
      logic [63:0] t;
      logic [31:0] p;
   } entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   logic [2:0]       req_command = CMD_MARK;
   logic [63:0]      req_entry_time = '0;
   logic [31:0]      req_entry_payload = '0;
   logic [63:0]      req_seen_time = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   logic             rsp_item_valid;
   logic [63:0]      rsp_item_time;
   logic [31:0]      rsp_item_payload;
   logic             rsp_last;
   logic             rsp_push_dropped;
   logic [CNT_W-1:0] rsp_occupancy;
   logic [CNT_W-1:0] rsp_high_water;
   logic [31:0]      rsp_pushed_total;
   logic [31:0]      rsp_dropped_total;
   logic [31:0]      rsp_popped_total;
   logic             rsp_drained;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [3:0]       csr_paddr = '0;
   logic [63:0]      csr_pwdata = '0;
   logic [63:0]      csr_prdata;
   logic             csr_pready;

   watermark_reorder_buffer_top dut (.*);

   // sorted copy of the store plus mirrored counters and registers
   entry_type   sorted_entries[$];
   logic [63:0] mark_time;
   logic        flushing;
   logic [6:0]  peak_count;
   logic [31:0] push_count, drop_count, pop_count;
   logic [6:0]  limit_reg;
   logic [63:0] delay_reg;

   req_type pending_words[$];
   rsp_type expected_words[$];

   int  failures = 0;
   int  checked_words = 0;
   int  released_count = 0;
   int  evicted_count = 0;
   bit  quiet = 1'b0;
   int  hold_request = 0;
   int  hold_seen = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   logic [63:0] time_base = 64'd0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("watermark_reorder_buffer_top_tb: FAIL");
      $finish;
   end

   function automatic int limit_now();
      if (limit_reg == 0 || limit_reg > DEPTH) return DEPTH;
      return limit_reg;
   endfunction

   function automatic bit head_ready();
      logic [63:0] thr;
      if (sorted_entries.size() == 0) return 1'b0;
      if (flushing) return 1'b1;
      thr = (mark_time > delay_reg) ? mark_time - delay_reg : 64'd0;
      return sorted_entries[0].t <= thr;
   endfunction

   function automatic rsp_type snapshot(logic valid, logic [63:0] t, logic [31:0] p,
                                        logic is_last, logic dropped);
      rsp_type r;
      r.item_valid    = valid;
      r.item_time     = valid ? t : 64'd0;
      r.item_payload  = valid ? p : 32'd0;
      r.last          = is_last;
      r.push_dropped  = dropped;
      r.occupancy     = 7'(sorted_entries.size());
      r.high_water    = peak_count;
      r.pushed_total  = push_count;
      r.dropped_total = drop_count;
      r.popped_total  = pop_count;
      r.drained       = flushing && sorted_entries.size() == 0;
      return r;
   endfunction

   task automatic append_expected(rsp_type r);
      expected_words = {expected_words, r};
   endtask

   task automatic predict_word(req_type w);
      entry_type e;
      int        pos;
      int        n;
      logic      dropped;
      dropped = 1'b0;
      case (w.command)
         CMD_PUSH: begin
            if (sorted_entries.size() >= limit_now() && sorted_entries.size() > 0) begin
               void'(sorted_entries.pop_front());
               drop_count++;
               evicted_count++;
               dropped = 1'b1;
            end
            e.t = w.entry_time;
            e.p = w.entry_payload;
            pos = 0;
            // ties go behind earlier pushes
            while (pos < sorted_entries.size() && sorted_entries[pos].t <= e.t) pos++;
            sorted_entries.insert(pos, e);
            push_count++;
            if (sorted_entries.size() > peak_count) peak_count = 7'(sorted_entries.size());
            append_expected(snapshot(1'b0, 0, 0, 1'b1, dropped));
         end
         CMD_MARK: begin
            mark_time = w.seen_time;
            append_expected(snapshot(1'b0, 0, 0, 1'b1, 1'b0));
         end
         CMD_POP_ONE: begin
            if (head_ready()) begin
               e = sorted_entries.pop_front();
               pop_count++;
               released_count++;
               append_expected(snapshot(1'b1, e.t, e.p, 1'b1, 1'b0));
            end else begin
               append_expected(snapshot(1'b0, 0, 0, 1'b1, 1'b0));
            end
         end
         CMD_POP_ALL: begin
            n = 0;
            while (head_ready() && n < DEPTH) begin
               e = sorted_entries.pop_front();
               pop_count++;
               released_count++;
               append_expected(snapshot(1'b1, e.t, e.p, 1'b0, 1'b0));
               n++;
            end
            if (n == 0) append_expected(snapshot(1'b0, 0, 0, 1'b1, 1'b0));
            else expected_words[$].last = 1'b1;
         end
         CMD_FINISH: begin
            flushing = 1'b1;
            append_expected(snapshot(1'b0, 0, 0, 1'b1, 1'b0));
         end
         default: begin
            append_expected(snapshot(1'b0, 0, 0, 1'b1, 1'b0));
         end
      endcase
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      req_type w;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            w.command       = req_command;
            w.entry_time    = req_entry_time;
            w.entry_payload = req_entry_payload;
            w.seen_time     = req_seen_time;
            predict_word(w);
         end
         if (!req_push || !req_full) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (pending_words.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 12) - 1;
               req_push <= 1'b0;
            end else if (pending_words.size() > 0) begin
               w = pending_words.pop_front();
               req_command       <= w.command;
               req_entry_time    <= w.entry_time;
               req_entry_payload <= w.entry_payload;
               req_seen_time     <= w.seen_time;
               req_push          <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected");
               failures++;
            end else begin
               want = expected_words.pop_front();
               checked_words++;
               check_field("item_valid", want.item_valid, rsp_item_valid);
               check_field("item_time", want.item_time, rsp_item_time);
               check_field("item_payload", want.item_payload, rsp_item_payload);
               check_field("last", want.last, rsp_last);
               check_field("push_dropped", want.push_dropped, rsp_push_dropped);
               check_field("occupancy", want.occupancy, rsp_occupancy);
               check_field("high_water", want.high_water, rsp_high_water);
               check_field("pushed_total", want.pushed_total, rsp_pushed_total);
               check_field("dropped_total", want.dropped_total, rsp_dropped_total);
               check_field("popped_total", want.popped_total, rsp_popped_total);
               check_field("drained", want.drained, rsp_drained);
            end
         end
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(1, 12) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic add_word(logic [2:0] cmd, logic [63:0] t, logic [31:0] p, logic [63:0] s);
      req_type w;
      w.command       = cmd;
      w.entry_time    = t;
      w.entry_payload = p;
      w.seen_time     = s;
      pending_words = {pending_words, w};
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic add_random(int count, bit allow_finish);
      int          pick;
      logic [2:0]  cmd;
      logic [63:0] t;
      logic [63:0] s;
      for (int i = 0; i < count; i++) begin
         time_base = time_base + $urandom_range(0, 20);
         pick = $urandom_range(0, 99);
         if (pick < 45) cmd = CMD_PUSH;
         else if (pick < 65) cmd = CMD_MARK;
         else if (pick < 80) cmd = CMD_POP_ONE;
         else if (pick < 93) cmd = CMD_POP_ALL;
         else if (pick < 96 && allow_finish) cmd = CMD_FINISH;
         else cmd = 3'($urandom_range(5, 7));
         t = ($urandom_range(0, 9) == 0) ? rand64() : time_base + $urandom_range(0, 60);
         s = ($urandom_range(0, 11) == 0) ? rand64() : time_base + $urandom_range(0, 40);
         add_word(cmd, t, $urandom, s);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_words.size() != 0 || req_push || expected_words.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [63:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_MAX_ENTRIES) limit_reg = data[6:0];
      else delay_reg = data;
   endtask

   initial begin
      sorted_entries.delete();
      mark_time  = '0;
      flushing   = 1'b0;
      peak_count = '0;
      push_count = '0;
      drop_count = '0;
      pop_count  = '0;
      limit_reg  = '0;
      delay_reg  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      csr_write(ADDR_MAX_ENTRIES, 64'd0);
      csr_write(ADDR_ORDER_DELAY, 64'd0);
      // extremes, ties, empty pops, unused codes
      add_word(CMD_PUSH, 64'd0, 32'd0, 64'd0);
      add_word(CMD_PUSH, ALL_ONES, 32'hFFFF_FFFF, 64'd0);
      add_word(CMD_PUSH, 64'd100, 32'd1, 64'd0);
      add_word(CMD_PUSH, 64'd100, 32'd2, 64'd0);
      add_word(CMD_PUSH, 64'd50, 32'hA5A5_5A5A, 64'd0);
      add_word(CMD_POP_ONE, 64'd0, 32'd0, 64'd0);
      add_word(CMD_POP_ALL, 64'd0, 32'd0, 64'd0);
      add_word(CMD_MARK, 64'd0, 32'd0, 64'd100);
      add_word(CMD_POP_ALL, 64'd0, 32'd0, 64'd0);
      add_word(CMD_POP_ONE, 64'd0, 32'd0, 64'd0);
      add_word(CMD_MARK, 64'd0, 32'd0, ALL_ONES);
      add_word(CMD_POP_ONE, 64'd0, 32'd0, 64'd0);
      add_word(CMD_POP_ONE, 64'd0, 32'd0, 64'd0);
      add_word(CMD_POP_ALL, 64'd0, 32'd0, 64'd0);
      add_word(CMD_UNUSED_5, ALL_ONES, 32'hFFFF_FFFF, ALL_ONES);
      add_word(CMD_UNUSED_6, 64'd0, 32'd0, 64'd0);
      add_word(CMD_UNUSED_7, 64'd0, 32'd0, 64'd0);
      add_word(CMD_MARK, 64'd0, 32'd0, 64'd0);
      for (int i = 0; i < 6; i++) add_word(CMD_PUSH, 64'(1000 + i), $urandom, 64'd0);
      wait_idle();

      // limit lowered below occupancy: each push evicts just one
      csr_write(ADDR_MAX_ENTRIES, 64'd2);
      add_word(CMD_PUSH, 64'd900, 32'd7, 64'd0);
      add_word(CMD_PUSH, 64'd900, 32'd8, 64'd0);
      add_word(CMD_MARK, 64'd0, 32'd0, ALL_ONES);
      add_word(CMD_POP_ALL, 64'd0, 32'd0, 64'd0);
      wait_idle();

      time_base = 64'd2000;
      csr_write(ADDR_MAX_ENTRIES, 64'd3);
      csr_write(ADDR_ORDER_DELAY, 64'd50);
      add_random(45, 1'b0);
      wait_idle();

      csr_write(ADDR_MAX_ENTRIES, 64'd1);
      csr_write(ADDR_ORDER_DELAY, ALL_ONES);
      add_random(40, 1'b0);
      wait_idle();

      // above the built depth: saturates
      csr_write(ADDR_MAX_ENTRIES, 64'd127);
      csr_write(ADDR_ORDER_DELAY, 64'd10);
      hold_request++;
      for (int i = 0; i < 30; i++)
         add_word(CMD_PUSH, time_base + $urandom_range(0, 60), $urandom, 64'd0);
      add_random(30, 1'b0);
      wait_idle();

      csr_write(ADDR_MAX_ENTRIES, 64'd64);
      csr_write(ADDR_ORDER_DELAY, 64'd0);
      add_random(50, 1'b0);
      wait_idle();

      // flushing is sticky, so it comes last
      quiet = 1'b1;
      csr_write(ADDR_MAX_ENTRIES, 64'd5);
      csr_write(ADDR_ORDER_DELAY, 64'd1000);
      add_word(CMD_PUSH, time_base, 32'd11, 64'd0);
      add_word(CMD_FINISH, 64'd0, 32'd0, 64'd0);
      add_word(CMD_PUSH, time_base + 5, 32'd12, 64'd0);
      add_word(CMD_MARK, 64'd0, 32'd0, 64'd0);
      add_word(CMD_FINISH, 64'd0, 32'd0, 64'd0);
      add_word(CMD_POP_ONE, 64'd0, 32'd0, 64'd0);
      add_word(CMD_POP_ALL, 64'd0, 32'd0, 64'd0);
      add_word(CMD_POP_ALL, 64'd0, 32'd0, 64'd0);
      add_random(30, 1'b1);
      add_word(CMD_POP_ALL, 64'd0, 32'd0, 64'd0);
      wait_idle();
      repeat (200) @(negedge clock);

      $display("Checked %0d result words: %0d entries released, %0d evicted.",
               checked_words, released_count, evicted_count);
      $display("Phases swept limits 0..127 and delays 0..max, with a long output hold.");
      if (failures == 0 && expected_words.size() == 0) begin
         $display("watermark_reorder_buffer_top_tb: PASS");
      end else begin
         if (expected_words.size() != 0)
            $error("%0d expected result words never arrived", expected_words.size());
         $display("watermark_reorder_buffer_top_tb: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hdl/wrb_pkg.sv
hdl/wrb_fifo.sv
hdl/wrb_back.sv
hdl/watermark_reorder_buffer_top.sv
verif/watermark_reorder_buffer_top_tb.sv
